// File: hdl/ashs_pkg.sv
// shared constants, types and register codes for the adc smoothing, hysteresis and scaling unit
// used by every module of the block except ashs_ram; depends on nothing
package ashs_pkg;

	localparam int CHANNELS       = 6;
	// must be a power of two, the divide is a shift
	localparam int SMOOTH_DIVISOR = 8;
	localparam int SMOOTH_SHIFT   = $clog2(SMOOTH_DIVISOR);

	localparam int CH_W      = 3;
	localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SAMPLE_W  = 12;
	localparam int VAL_W     = 16;
	localparam int PROD_W    = SAMPLE_W + VAL_W;
	localparam int FULL_SCALE = 4095;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_BAND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX  = 2'd2;

	localparam logic [SAMPLE_W-1:0] BAND_RST = 12'd10;
	localparam logic [VAL_W-1:0]    MIN_RST  = 16'd0;
	localparam logic [VAL_W-1:0]    MAX_RST  = 16'd4095;

	// control that travels with each item down the pipeline
	typedef struct packed {
		logic            vld;
		logic            err;
		logic [CH_W-1:0] ch;
	} ctrl_t;

	typedef struct packed {
		logic        [SAMPLE_W-1:0] band;
		logic signed [VAL_W-1:0]    smin;
		logic signed [VAL_W-1:0]    smax;
	} cfg_t;

endpackage

// File: hdl/ashs_ram.sv
// generic synchronous ram, one write and one registered read port, per-entry written bits
// entries never written read as zero; no package dependency
module ashs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] written_q;
	logic [WIDTH-1:0] rd_raw_q;
	logic             rd_ok_q;
	logic             rd_in_range;

	assign rd_in_range = ({1'b0, rd_addr} < (AW+1)'(DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en && rd_in_range) begin
			rd_raw_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_ok_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_ok_q <= rd_in_range && written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_ok_q ? rd_raw_q : '0;

endmodule

// File: hdl/ashs_track.sv
// per-channel running average and hysteresis hold, read-modify-write on a state ram
// depends on ashs_pkg and ashs_ram
module ashs_track (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  ashs_pkg::ctrl_t                in_ctrl,
	input  logic [ashs_pkg::SAMPLE_W-1:0]  in_sample,
	input  logic [ashs_pkg::SAMPLE_W-1:0]  band,
	output ashs_pkg::ctrl_t                ctrl_s2,
	output logic [ashs_pkg::SAMPLE_W-1:0]  held_s2
);

	localparam int SW = ashs_pkg::SAMPLE_W;
	localparam int EW = 2 * SW;

	ashs_pkg::ctrl_t ctrl_s1;
	logic [SW-1:0]   sample_s1;

	logic [EW-1:0]   rd_data;
	logic [EW-1:0]   cur;
	logic [EW-1:0]   wr_data;
	logic            wr_en;

	logic            fwd_vld_q;
	logic [ashs_pkg::CH_W-1:0] fwd_ch_q;
	logic [EW-1:0]   fwd_data_q;

	logic [SW-1:0]   avg_old;
	logic [SW-1:0]   held_old;
	logic [SW-1:0]   avg_new;
	logic [SW-1:0]   held_new;
	logic            move;

	ashs_ram #(
		.WIDTH (EW),
		.DEPTH (ashs_pkg::CHANNELS),
		.AW    (ashs_pkg::CH_AW)
	) u_state_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (adv),
		.rd_addr (in_ctrl.ch[ashs_pkg::CH_AW-1:0]),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (ctrl_s1.ch[ashs_pkg::CH_AW-1:0]),
		.wr_data (wr_data)
	);

	// the item just ahead may have written this channel after our read was issued
	assign cur      = (fwd_vld_q && fwd_ch_q == ctrl_s1.ch) ? fwd_data_q : rd_data;
	assign avg_old  = cur[EW-1:SW];
	assign held_old = cur[SW-1:0];

	assign avg_new = avg_old - (avg_old >> ashs_pkg::SMOOTH_SHIFT)
		+ (sample_s1 >> ashs_pkg::SMOOTH_SHIFT);

	assign move = ({1'b0, avg_new} > ({1'b0, held_old} + {1'b0, band}))
		|| (({1'b0, avg_new} + {1'b0, band}) < {1'b0, held_old});

	assign held_new = move ? avg_new : held_old;
	assign wr_data  = {avg_new, held_new};
	assign wr_en    = adv && ctrl_s1.vld && !ctrl_s1.err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1   <= '0;
			ctrl_s2   <= '0;
			fwd_vld_q <= 1'b0;
		end else if (adv) begin
			ctrl_s1   <= in_ctrl;
			ctrl_s2   <= ctrl_s1;
			fwd_vld_q <= ctrl_s1.vld && !ctrl_s1.err;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1  <= in_sample;
			held_s2    <= held_new;
			fwd_ch_q   <= ctrl_s1.ch;
			fwd_data_q <= wr_data;
		end
	end

endmodule

// File: hdl/ashs_scale.sv
// linear scaling of the held reading: multiply by the output span, then divide by full scale
// depends on ashs_pkg; the divide is a reciprocal estimate plus one correction step
module ashs_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  ashs_pkg::ctrl_t               ctrl_s2,
	input  logic [ashs_pkg::SAMPLE_W-1:0] held_s2,
	input  ashs_pkg::cfg_t                cfg,
	output ashs_pkg::ctrl_t               ctrl_s4,
	output ashs_pkg::ctrl_t               ctrl_s5,
	output logic [ashs_pkg::VAL_W-1:0]    quot_s5
);

	localparam int PW = ashs_pkg::PROD_W;
	localparam int VW = ashs_pkg::VAL_W;

	ashs_pkg::ctrl_t ctrl_s3;
	logic [VW:0]     span;
	logic [PW-1:0]   prod_s3;
	logic [PW-1:0]   prod_s4;
	logic [PW:0]     est_sum;
	logic [VW-1:0]   q0_s4;
	logic [PW-1:0]   q0_times;
	logic [PW-1:0]   rem;

	// only used when max is above min, then it fits in VAL_W unsigned bits
	assign span = {cfg.smax[VW-1], cfg.smax} - {cfg.smin[VW-1], cfg.smin};

	// p * 4097 / 2^24 never exceeds p / 4095 and falls short by at most one
	assign est_sum = {1'b0, prod_s3} + {13'b0, prod_s3[PW-1:12]};

	// q0 * 4095 as q0 * 4096 - q0
	assign q0_times = {q0_s4, 12'b0} - {12'b0, q0_s4};
	assign rem      = prod_s4 - q0_times;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
			ctrl_s5 <= '0;
		end else if (adv) begin
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= ctrl_s3;
			ctrl_s5 <= ctrl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= held_s2 * span[VW-1:0];
			prod_s4 <= prod_s3;
			q0_s4   <= est_sum[PW-1:12];
			quot_s5 <= q0_s4 + VW'(rem >= PW'(ashs_pkg::FULL_SCALE));
		end
	end

endmodule

// File: hdl/ashs_report.sv
// final stage: offset by scale_min, compare against the last reported value per channel
// holds that value in a ram with forwarding, and drives the output register; needs ashs_pkg, ashs_ram
module ashs_report (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  ashs_pkg::ctrl_t            ctrl_s4,
	input  ashs_pkg::ctrl_t            ctrl_s5,
	input  logic [ashs_pkg::VAL_W-1:0] quot_s5,
	input  ashs_pkg::cfg_t             cfg,
	output logic                       out_valid,
	output logic [ashs_pkg::CH_W-1:0]  out_channel,
	output logic [ashs_pkg::VAL_W-1:0] scaled_value,
	output logic                       value_changed,
	output logic                       channel_error
);

	localparam int VW = ashs_pkg::VAL_W;

	logic [VW-1:0] rd_data;
	logic [VW-1:0] last;
	logic [VW-1:0] scaled;
	logic          changed;
	logic          wr_en;

	logic                      fwd_vld_q;
	logic [ashs_pkg::CH_W-1:0] fwd_ch_q;
	logic [VW-1:0]             fwd_data_q;

	ashs_ram #(
		.WIDTH (VW),
		.DEPTH (ashs_pkg::CHANNELS),
		.AW    (ashs_pkg::CH_AW)
	) u_last_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (adv),
		.rd_addr (ctrl_s4.ch[ashs_pkg::CH_AW-1:0]),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (ctrl_s5.ch[ashs_pkg::CH_AW-1:0]),
		.wr_data (scaled)
	);

	assign last = (fwd_vld_q && fwd_ch_q == ctrl_s5.ch) ? fwd_data_q : rd_data;

	// empty or inverted range reports scale_min
	assign scaled  = (cfg.smax > cfg.smin) ? (cfg.smin + quot_s5) : cfg.smin;
	assign changed = (scaled != last);
	assign wr_en   = adv && ctrl_s5.vld && !ctrl_s5.err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else if (adv) begin
			out_valid <= ctrl_s5.vld;
			fwd_vld_q <= ctrl_s5.vld && !ctrl_s5.err;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_ch_q      <= ctrl_s5.ch;
			fwd_data_q    <= scaled;
			out_channel   <= ctrl_s5.ch;
			channel_error <= ctrl_s5.err;
			scaled_value  <= ctrl_s5.err ? '0 : scaled;
			value_changed <= ctrl_s5.err ? 1'b0 : changed;
		end
	end

endmodule

// File: hdl/adc_smooth_hysteresis_scale_unit.sv
// top level of the adc smoothing, hysteresis and scaling unit
// depends on ashs_pkg, ashs_track, ashs_scale and ashs_report
//
// usage:
//   s_* carries converter samples tagged with a channel number, one item per cycle at most.
//   m_* returns exactly one result item per sample, in order: the channel, the held reading
//   mapped onto [scale_min, scale_max], a changed flag, and in tuser an error flag for a
//   channel number at or above the channel count (such items leave all state untouched).
//   cfg_* writes hysteresis_band (0), scale_min (1) and scale_max (2) while no item is in flight.
// timing:
//   an item accepted on s_* passes the ram read and the stages below to reach m_tvalid; the unit
//   takes one item every cycle unless the output stalls, with same-channel items back to back
//   handled by forwarding around the two per-channel state rams (average/held, last reported value).
//   after the ram read the five stages are: average and hold update, multiply, quotient
//   estimate, correction, then the offset and last-value compare into the output register.
// reset and stall:
//   reset empties the pipe, restores the register defaults and marks every channel's
//   state as zero; s_tready and cfg_ready stay low until the first edge after reset.
//   while m_tvalid is high and m_tready low the whole pipe holds, bubbles included,
//   and s_tready drops in that same cycle.
module adc_smooth_hysteresis_scale_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [15:0]                        s_tdata,   // channel[2:0], sample[14:3], zero
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// out_channel[2:0], scaled_value[18:3], value_changed[19], zero[23:20]
	output logic [23:0]                        m_tdata,
	output logic                               m_tuser,   // channel_error
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ashs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [15:0]                        cfg_data
);

	localparam int CW = ashs_pkg::CH_W;
	localparam int SW = ashs_pkg::SAMPLE_W;
	localparam int VW = ashs_pkg::VAL_W;

	logic            adv;
	logic            run_q;
	ashs_pkg::cfg_t  cfg_q;
	ashs_pkg::ctrl_t in_ctrl;
	ashs_pkg::ctrl_t ctrl_s2;
	ashs_pkg::ctrl_t ctrl_s4;
	ashs_pkg::ctrl_t ctrl_s5;
	logic [SW-1:0]   held_s2;
	logic [VW-1:0]   quot_s5;

	logic [CW-1:0]   out_channel;
	logic [VW-1:0]   scaled_value;
	logic            value_changed;
	logic            channel_error;

	// the pipe moves whenever the output register is free or being emptied
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv && run_q;
	assign cfg_ready = run_q;

	assign in_ctrl.vld = s_tvalid && run_q;
	assign in_ctrl.ch  = s_tdata[CW-1:0];
	assign in_ctrl.err = !({1'b0, s_tdata[CW-1:0]} < (CW+1)'(ashs_pkg::CHANNELS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band <= ashs_pkg::BAND_RST;
			cfg_q.smin <= ashs_pkg::MIN_RST;
			cfg_q.smax <= ashs_pkg::MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ashs_pkg::REG_BAND: cfg_q.band <= cfg_data[SW-1:0];
				ashs_pkg::REG_MIN:  cfg_q.smin <= cfg_data;
				ashs_pkg::REG_MAX:  cfg_q.smax <= cfg_data;
				default: ;
			endcase
		end
	end

	ashs_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_ctrl   (in_ctrl),
		.in_sample (s_tdata[CW+SW-1:CW]),
		.band      (cfg_q.band),
		.ctrl_s2   (ctrl_s2),
		.held_s2   (held_s2)
	);

	ashs_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctrl_s2 (ctrl_s2),
		.held_s2 (held_s2),
		.cfg     (cfg_q),
		.ctrl_s4 (ctrl_s4),
		.ctrl_s5 (ctrl_s5),
		.quot_s5 (quot_s5)
	);

	ashs_report u_report (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.ctrl_s4       (ctrl_s4),
		.ctrl_s5       (ctrl_s5),
		.quot_s5       (quot_s5),
		.cfg           (cfg_q),
		.out_valid     (m_tvalid),
		.out_channel   (out_channel),
		.scaled_value  (scaled_value),
		.value_changed (value_changed),
		.channel_error (channel_error)
	);

	assign m_tdata = {4'b0, value_changed, scaled_value, out_channel};
	assign m_tuser = channel_error;

endmodule
